// ----- hw/rtl/mqttcpc_pkg.sv -----
package mqttcpc_pkg;

    // parse position inside one CONNECT body
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CLIENT = 3'd1,
        PH_WTOPIC = 3'd2,
        PH_WMSG   = 3'd3,
        PH_USER   = 3'd4,
        PH_PASS   = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    // error causes, in check order
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_HDR_FLAGS  = 4'd1;
    localparam logic [3:0] ERR_SHORT_HDR  = 4'd2;
    localparam logic [3:0] ERR_PROTO_NAME = 4'd3;
    localparam logic [3:0] ERR_RESERVED   = 4'd4;
    localparam logic [3:0] ERR_QOS3       = 4'd5;
    localparam logic [3:0] ERR_QOS_NOWILL = 4'd6;
    localparam logic [3:0] ERR_RET_NOWILL = 4'd7;
    localparam logic [3:0] ERR_CUT_CLIENT = 4'd8;
    localparam logic [3:0] ERR_CUT_WTOPIC = 4'd9;
    localparam logic [3:0] ERR_CUT_WMSG   = 4'd10;
    localparam logic [3:0] ERR_CUT_USER   = 4'd11;
    localparam logic [3:0] ERR_CUT_PASS   = 4'd12;
    localparam logic [3:0] ERR_EXTRA      = 4'd13;
    localparam logic [3:0] ERR_LEVEL      = 4'd14;
    localparam logic [3:0] ERR_EMPTY_ID   = 4'd15;

    // verdict codes
    localparam logic [1:0] VD_ACCEPT     = 2'd0;
    localparam logic [1:0] VD_DROP       = 2'd1;
    localparam logic [1:0] VD_REFUSE_VER = 2'd2;
    localparam logic [1:0] VD_REFUSE_ID  = 2'd3;

    // connect flag bit positions
    localparam int FL_RESERVED = 0;
    localparam int FL_CLEAN    = 1;
    localparam int FL_WILL     = 2;
    localparam int FL_QOS_LO   = 3;
    localparam int FL_RETAIN   = 5;
    localparam int FL_PASSWORD = 6;
    localparam int FL_USER     = 7;

    localparam logic [3:0] HDR_BYTES   = 4'd10;
    localparam logic [7:0] NAME_LEN_LO = 8'd4;
    localparam logic [1:0] QOS_BAD     = 2'd3;

    // expected protocol name characters
    function automatic logic [7:0] name_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h4D;  // M
            2'd1:    ch = 8'h51;  // Q
            default: ch = 8'h54;  // T
        endcase
        return ch;
    endfunction

    // next payload string that the connect flags call for
    function automatic phase_t next_phase(input phase_t p, input logic [7:0] fl);
        phase_t n;
        case (p)
            PH_HEADER: n = PH_CLIENT;
            PH_CLIENT: n = fl[FL_WILL] ? PH_WTOPIC :
                           fl[FL_USER] ? PH_USER :
                           fl[FL_PASSWORD] ? PH_PASS : PH_DONE;
            PH_WTOPIC: n = PH_WMSG;
            PH_WMSG:   n = fl[FL_USER] ? PH_USER :
                           fl[FL_PASSWORD] ? PH_PASS : PH_DONE;
            PH_USER:   n = fl[FL_PASSWORD] ? PH_PASS : PH_DONE;
            default:   n = PH_DONE;
        endcase
        return n;
    endfunction

    // cause for a string that never completed
    function automatic logic [3:0] cut_cause(input phase_t p);
        logic [3:0] c;
        case (p)
            PH_CLIENT: c = ERR_CUT_CLIENT;
            PH_WTOPIC: c = ERR_CUT_WTOPIC;
            PH_WMSG:   c = ERR_CUT_WMSG;
            PH_USER:   c = ERR_CUT_USER;
            PH_PASS:   c = ERR_CUT_PASS;
            default:   c = ERR_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/mqtt_connect_packet_checker_core.sv -----
// Path: an accepted item is held in the input register; a last item's result is then
// loaded into the result register and driven on m_tdata; a result still waiting on
// m_tready holds back a last item.
// Throughput: one item per cycle unless a last item is held back, set by the parse
// step, combinational between the input register and the parse state / result register.
// Reset: synchronous active-low aresetn clears parse state and valid flags and
// sets required_level to 4.
module mqtt_connect_packet_checker_core
    import mqttcpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: required_level
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [5:0]  s_tuser,   // [0] has_data, [1] first_item, [5:2] header_flags
    input  logic        s_tlast,   // last_item
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] verdict, [5:2] error_cause, [21:6] keep_alive_sec, [22] clean_session,
    // [23] has_will, [25:24] will_qos, [26] will_retain, [27] has_user_name,
    // [28] has_password, [44:29] client_id_length, [47:45] zero
    output logic [47:0] m_tdata
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_has_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    logic [3:0]  in_hflags_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [3:0]  sect_cnt_reg, sect_cnt_next;
    logic [15:0] str_len_reg, str_len_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  level_reg, level_next;
    logic [15:0] keep_reg, keep_next;
    logic [15:0] id_len_reg, id_len_next;
    logic [3:0]  err_reg, err_next;
    logic        ffb_reg, ffb_next;
    logic [7:0]  req_level_reg;

    // result register
    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic [47:0] out_data_next;

    logic advance;
    logic out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg   <= s_tdata;
            in_has_reg    <= s_tuser[0];
            in_first_reg  <= s_tuser[1];
            in_hflags_reg <= s_tuser[5:2];
            in_last_reg   <= s_tlast;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_level_reg <= 8'd4;
        end else if (cfg_we) begin
            req_level_reg <= cfg_wdata;
        end
    end

    // parse step for the registered item
    always_comb begin
        phase_t      ph;
        logic [3:0]  cnt;
        logic [15:0] slen;
        logic [7:0]  fl;
        logic [7:0]  lvl;
        logic [15:0] ka;
        logic [15:0] idl;
        logic [3:0]  err;
        logic        ffb;
        logic [7:0]  b;
        logic [1:0]  qos;
        logic [15:0] slen_dec;
        logic [3:0]  cause;
        logic [1:0]  verdict;

        ph  = phase_reg;
        cnt = sect_cnt_reg;
        slen = str_len_reg;
        fl  = flags_reg;
        lvl = level_reg;
        ka  = keep_reg;
        idl = id_len_reg;
        err = err_reg;
        ffb = ffb_reg;
        b   = in_byte_reg;
        qos = in_byte_reg[FL_QOS_LO+1:FL_QOS_LO];
        slen_dec = str_len_reg - 16'd1;
        cause   = ERR_NONE;
        verdict = VD_ACCEPT;

        // a first item restarts the message
        if (in_first_reg) begin
            ph   = PH_HEADER;
            cnt  = 4'd0;
            slen = 16'd0;
            fl   = 8'd0;
            lvl  = 8'd0;
            ka   = 16'd0;
            idl  = 16'd0;
            err  = ERR_NONE;
            ffb  = (in_hflags_reg != 4'd0);
            slen_dec = 16'hFFFF;
        end

        // take the byte
        if (in_has_reg) begin
            if (ph == PH_HEADER) begin
                if (cnt == 4'd0 && b != 8'd0 && err == ERR_NONE) err = ERR_PROTO_NAME;
                if (cnt == 4'd1 && b != NAME_LEN_LO && err == ERR_NONE) err = ERR_PROTO_NAME;
                if (cnt >= 4'd2 && cnt <= 4'd5 && b != name_char(cnt[1:0] - 2'd2)
                    && err == ERR_NONE) err = ERR_PROTO_NAME;
                if (cnt == 4'd6) lvl = b;
                if (cnt == 4'd7) begin
                    fl = b;
                    if (err == ERR_NONE) begin
                        if (b[FL_RESERVED]) err = ERR_RESERVED;
                        else if (b[FL_WILL]) begin
                            if (qos == QOS_BAD) err = ERR_QOS3;
                        end else if (qos != 2'd0) err = ERR_QOS_NOWILL;
                        else if (b[FL_RETAIN]) err = ERR_RET_NOWILL;
                    end
                end
                if (cnt == 4'd8) ka = {b, 8'd0};
                if (cnt == 4'd9) ka = {ka[15:8], b};
                if (cnt + 4'd1 >= HDR_BYTES) begin
                    ph   = next_phase(ph, fl);
                    cnt  = 4'd0;
                    slen = 16'd0;
                end else begin
                    cnt = cnt + 4'd1;
                end
            end else if (ph != PH_DONE) begin
                if (cnt == 4'd0) begin
                    slen = {b, 8'd0};
                    cnt  = 4'd1;
                end else if (cnt == 4'd1) begin
                    slen = {slen[15:8], b};
                    cnt  = 4'd2;
                    if (ph == PH_CLIENT) idl = slen;
                    if (slen == 16'd0) begin
                        ph  = next_phase(ph, fl);
                        cnt = 4'd0;
                    end
                end else begin
                    slen = slen_dec;
                    if (slen == 16'd0) begin
                        ph  = next_phase(ph, fl);
                        cnt = 4'd0;
                    end
                end
            end else if (err == ERR_NONE) begin
                err = ERR_EXTRA;
            end
        end

        // verdict on the last item
        if (ffb) cause = ERR_HDR_FLAGS;
        else if (ph == PH_HEADER) cause = ERR_SHORT_HDR;
        else if (err != ERR_NONE) cause = err;
        else if (ph != PH_DONE) cause = cut_cause(ph);
        else if (lvl != req_level_reg) cause = ERR_LEVEL;
        else if (idl == 16'd0 && !fl[FL_CLEAN]) cause = ERR_EMPTY_ID;

        case (cause)
            ERR_NONE:     verdict = VD_ACCEPT;
            ERR_LEVEL:    verdict = VD_REFUSE_VER;
            ERR_EMPTY_ID: verdict = VD_REFUSE_ID;
            default:      verdict = VD_DROP;
        endcase

        out_data_next = {3'd0, idl, fl[FL_PASSWORD], fl[FL_USER], fl[FL_RETAIN],
                         fl[FL_QOS_LO+1:FL_QOS_LO], fl[FL_WILL], fl[FL_CLEAN],
                         ka, cause, verdict};

        // a last item leaves the state clear for the next message
        if (in_last_reg) begin
            phase_next    = PH_HEADER;
            sect_cnt_next = 4'd0;
            str_len_next  = 16'd0;
            flags_next    = 8'd0;
            level_next    = 8'd0;
            keep_next     = 16'd0;
            id_len_next   = 16'd0;
            err_next      = ERR_NONE;
            ffb_next      = 1'b0;
        end else begin
            phase_next    = ph;
            sect_cnt_next = cnt;
            str_len_next  = slen;
            flags_next    = fl;
            level_next    = lvl;
            keep_next     = ka;
            id_len_next   = idl;
            err_next      = err;
            ffb_next      = ffb;
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            sect_cnt_reg <= 4'd0;
            str_len_reg  <= 16'd0;
            flags_reg    <= 8'd0;
            level_reg    <= 8'd0;
            keep_reg     <= 16'd0;
            id_len_reg   <= 16'd0;
            err_reg      <= ERR_NONE;
            ffb_reg      <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            sect_cnt_reg <= sect_cnt_next;
            str_len_reg  <= str_len_next;
            flags_reg    <= flags_next;
            level_reg    <= level_next;
            keep_reg     <= keep_next;
            id_len_reg   <= id_len_next;
            err_reg      <= err_next;
            ffb_reg      <= ffb_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- verif/tb_mqtt_connect_packet_checker_core.sv -----
module tb_mqtt_connect_packet_checker_core;
    import mqttcpc_pkg::*;

    localparam int WD_LIMIT  = 2000;
    localparam int MAX_SHOWN = 10;
    localparam int PHASE_ITEMS = 110;
    localparam int NO_CAP = 100000;
    localparam logic [31:0] PROTO_NAME = "MQTT";

    // one result item, laid out as on m_tdata (lowest field last)
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] id_len;
        logic        has_pass;
        logic        has_user;
        logic        retain;
        logic [1:0]  qos;
        logic        will;
        logic        clean;
        logic [15:0] keep_alive;
        logic [3:0]  cause;
        logic [1:0]  verdict;
    } verdict_t;

    // one input item
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       first;
        logic       last;
        logic [3:0] hflags;
    } body_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
    logic [5:0]  s_tuser = 6'd0;   // [0] has_data, [1] first_item, [5:2] header_flags
    logic        s_tlast = 1'b0;   // last_item
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [47:0] m_tdata;          // verdict_t layout, verdict in the lowest bits

    mqtt_connect_packet_checker_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser state mirrored by the testbench
    logic [7:0]  lvl_req = 8'd4;
    phase_t      pst = PH_HEADER;
    logic [15:0] sec_cnt = 16'd0;
    logic [15:0] owed = 16'd0;
    logic [7:0]  cflags = 8'd0;
    logic [7:0]  lvl_seen = 8'd0;
    logic [15:0] ka_acc = 16'd0;
    logic [15:0] id_seen = 16'd0;
    logic [3:0]  err_first = ERR_NONE;
    logic        hdr_bad = 1'b0;

    verdict_t    verdict_q[$];
    body_item_t  pend_q[$];
    logic [7:0]  body[$];
    body_item_t  on_bus;
    bit          cause_hit[16];

    int src_gap = 0, src_quiet = 0, sink_hold = 0, sink_quiet = 0;
    int quiet_cycles = 0;
    int mism = 0, n_results = 0, n_queued = 0, n_msgs = 0, n_levels = 1;

    // ---------------- predictor ----------------

    task automatic clear_msg();
        pst = PH_HEADER;
        sec_cnt = 16'd0;
        owed = 16'd0;
        cflags = 8'd0;
        lvl_seen = 8'd0;
        ka_acc = 16'd0;
        id_seen = 16'd0;
        err_first = ERR_NONE;
        hdr_bad = 1'b0;
    endtask

    task automatic flag_err(logic [3:0] c);
        if (err_first == ERR_NONE) err_first = c;
    endtask

    function automatic bit string_wanted(phase_t p, logic [7:0] fl);
        case (p)
            PH_WTOPIC, PH_WMSG: return fl[FL_WILL];
            PH_USER:            return fl[FL_USER];
            PH_PASS:            return fl[FL_PASSWORD];
            default:            return 1'b1;
        endcase
    endfunction

    // skip strings that the connect flags leave out
    task automatic advance_section();
        phase_t n;
        n = phase_t'(pst + 3'd1);
        while (n < PH_DONE && !string_wanted(n, cflags)) n = phase_t'(n + 3'd1);
        pst = n;
        sec_cnt = 16'd0;
        owed = 16'd0;
    endtask

    task automatic take_header_byte(logic [7:0] b);
        int idx;
        logic [1:0] q;
        idx = sec_cnt;
        q = b[FL_QOS_LO +: 2];
        case (idx)
            0: if (b != 8'h00) flag_err(ERR_PROTO_NAME);
            1: if (b != NAME_LEN_LO) flag_err(ERR_PROTO_NAME);
            2, 3, 4, 5: if (b != PROTO_NAME[31 - 8 * (idx - 2) -: 8]) flag_err(ERR_PROTO_NAME);
            6: lvl_seen = b;
            7: begin
                cflags = b;
                if (b[FL_RESERVED]) flag_err(ERR_RESERVED);
                else if (b[FL_WILL]) begin
                    if (q == QOS_BAD) flag_err(ERR_QOS3);
                end else if (q != 2'd0) flag_err(ERR_QOS_NOWILL);
                else if (b[FL_RETAIN]) flag_err(ERR_RET_NOWILL);
            end
            8: ka_acc = {b, 8'h00};
            9: ka_acc[7:0] = b;
            default: ;
        endcase
        sec_cnt = sec_cnt + 16'd1;
        if (sec_cnt >= HDR_BYTES) advance_section();
    endtask

    task automatic take_string_byte(logic [7:0] b);
        if (sec_cnt == 16'd0) begin
            owed = {b, 8'h00};
            sec_cnt = 16'd1;
        end else if (sec_cnt == 16'd1) begin
            owed[7:0] = b;
            sec_cnt = 16'd2;
            if (pst == PH_CLIENT) id_seen = owed;
            if (owed == 16'd0) advance_section();
        end else begin
            owed = owed - 16'd1;
            if (owed == 16'd0) advance_section();
        end
    endtask

    task automatic parse_connect_item(body_item_t it);
        verdict_t r;
        r = '0;
        if (it.first) begin
            clear_msg();
            hdr_bad = (it.hflags != 4'd0);
        end
        if (it.has_data) begin
            if (pst == PH_HEADER) take_header_byte(it.data);
            else if (pst < PH_DONE) take_string_byte(it.data);
            else flag_err(ERR_EXTRA);
        end
        if (it.last) begin
            // error precedence: fixed header, short header, stream error, cut string,
            // then level and empty id
            if (hdr_bad) r.cause = ERR_HDR_FLAGS;
            else if (pst == PH_HEADER) r.cause = ERR_SHORT_HDR;
            else if (err_first != ERR_NONE) r.cause = err_first;
            else if (pst < PH_DONE) r.cause = 4'(ERR_CUT_CLIENT + (pst - PH_CLIENT));
            else if (lvl_seen != lvl_req) r.cause = ERR_LEVEL;
            else if (id_seen == 16'd0 && !cflags[FL_CLEAN]) r.cause = ERR_EMPTY_ID;
            else r.cause = ERR_NONE;
            r.verdict = (r.cause == ERR_NONE)     ? VD_ACCEPT :
                        (r.cause == ERR_LEVEL)    ? VD_REFUSE_VER :
                        (r.cause == ERR_EMPTY_ID) ? VD_REFUSE_ID : VD_DROP;
            r.keep_alive = ka_acc;
            r.clean = cflags[FL_CLEAN];
            r.will = cflags[FL_WILL];
            r.qos = cflags[FL_QOS_LO +: 2];
            r.retain = cflags[FL_RETAIN];
            r.has_user = cflags[FL_USER];
            r.has_pass = cflags[FL_PASSWORD];
            r.id_len = id_seen;
            verdict_q.push_back(r);
            clear_msg();
        end
    endtask

    // ---------------- result checking ----------------

    function automatic string fmt_verdict(verdict_t v);
        return $sformatf("vd=%0d cause=%0d ka=%h cs=%b will=%b qos=%0d ret=%b user=%b pw=%b id=%h",
                         v.verdict, v.cause, v.keep_alive, v.clean, v.will, v.qos, v.retain,
                         v.has_user, v.has_pass, v.id_len);
    endfunction

    task automatic check_result(logic [47:0] bus);
        verdict_t got, want;
        bit bad;
        got = verdict_t'(bus);
        n_results++;
        if (verdict_q.size() == 0) begin
            mism++;
            if (mism <= MAX_SHOWN) $display("Unexpected result at %0t: %s", $time, fmt_verdict(got));
        end else begin
            want = verdict_q.pop_front();
            cause_hit[want.cause] = 1'b1;
            bad = (got.verdict != want.verdict) || (got.cause != want.cause) ||
                  (got.keep_alive != want.keep_alive) || (got.clean != want.clean) ||
                  (got.will != want.will) || (got.qos != want.qos) ||
                  (got.retain != want.retain) || (got.has_user != want.has_user) ||
                  (got.has_pass != want.has_pass) || (got.id_len != want.id_len);
            if (bad) begin
                mism++;
                if (mism <= MAX_SHOWN) begin
                    $display("Mismatch on result %0d at %0t", n_results, $time);
                    $display("  expected %s", fmt_verdict(want));
                    $display("  actual   %s", fmt_verdict(got));
                end
            end
        end
    endtask

    // ---------------- idle pattern ----------------

    // mostly short gaps, a few long ones, and occasional runs with none
    function automatic int gap_len(inout int quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if (r < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 87) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) parse_connect_item(on_bus);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    on_bus = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= on_bus.data;
                    s_tuser <= {on_bus.hflags, on_bus.first, on_bus.has_data};
                    s_tlast <= on_bus.last;
                    src_gap = gap_len(src_quiet);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            sink_hold = gap_len(sink_quiet);
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, verdict_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    task automatic add_item(logic [7:0] d, logic hd, logic f, logic l, logic [3:0] hf);
        body_item_t it;
        it.data = d;
        it.has_data = hd;
        it.first = f;
        it.last = l;
        it.hflags = hf;
        pend_q.push_back(it);
        n_queued++;
    endtask

    // length prefix then body bytes, never past cap
    task automatic add_string(int len, int cap);
        body.push_back(len[15:8]);
        body.push_back(len[7:0]);
        for (int j = 0; j < len && body.size() < cap; j++) body.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_connect(logic [7:0] lvl, logic [7:0] fl, logic [15:0] ka, int id_len,
                                 int t_len, int m_len, int u_len, int p_len, int cap,
                                 int extra, bit bad_name);
        int k;
        body.delete();
        body.push_back(8'h00);
        body.push_back(NAME_LEN_LO);
        for (k = 0; k < 4; k++) body.push_back(PROTO_NAME[31 - 8 * k -: 8]);
        body.push_back(lvl);
        body.push_back(fl);
        body.push_back(ka[15:8]);
        body.push_back(ka[7:0]);
        if (bad_name) begin
            k = $urandom_range(0, 5);
            body[k] = body[k] ^ 8'($urandom_range(1, 255));
        end
        add_string(id_len, cap);
        if (fl[FL_WILL]) begin
            add_string(t_len, cap);
            add_string(m_len, cap);
        end
        if (fl[FL_USER]) add_string(u_len, cap);
        if (fl[FL_PASSWORD]) add_string(p_len, cap);
        while (body.size() > cap) void'(body.pop_back());
        repeat (extra) body.push_back(8'($urandom_range(0, 255)));
    endtask

    // turn the byte list into items; empty items may carry the markers or sit in between
    task automatic send_body(logic [3:0] hfl, bit with_first, bit with_last);
        int n;
        bit lead, tail, f;
        n = body.size();
        lead = (n == 0) || ($urandom_range(0, 99) < 5);
        tail = (n > 0) && ($urandom_range(0, 99) < 8);
        if (lead) add_item(8'($urandom_range(0, 255)), 1'b0, with_first, (n == 0) && with_last, hfl);
        for (int i = 0; i < n; i++) begin
            f = (i == 0) && with_first && !lead;
            add_item(body[i], 1'b1, f, (i == n - 1) && with_last && !tail,
                     f ? hfl : 4'($urandom_range(0, 15)));
            if (i < n - 1 && $urandom_range(0, 99) < 4)
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 4'($urandom_range(0, 15)));
        end
        if (tail) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, with_last, 4'($urandom_range(0, 15)));
        n_msgs++;
    endtask

    task automatic random_message();
        logic [7:0] fl, lvl;
        logic [15:0] ka;
        int id_len, cap, r;
        logic [3:0] hfl;
        hfl = ($urandom_range(0, 99) < 90) ? 4'd0 : 4'($urandom_range(1, 15));
        if ($urandom_range(0, 99) < 6) begin
            // raw noise
            body.delete();
            repeat ($urandom_range(1, 14)) body.push_back(8'($urandom_range(0, 255)));
            send_body(4'($urandom_range(0, 15)), $urandom_range(0, 99) < 80, 1'b1);
        end else begin
            if ($urandom_range(0, 99) < 72) begin
                fl = 8'd0;
                fl[FL_CLEAN] = 1'($urandom_range(0, 1));
                fl[FL_WILL] = 1'($urandom_range(0, 1));
                if (fl[FL_WILL]) begin
                    fl[FL_QOS_LO +: 2] = 2'($urandom_range(0, 2));
                    fl[FL_RETAIN] = 1'($urandom_range(0, 1));
                end
                fl[FL_USER] = 1'($urandom_range(0, 1));
                fl[FL_PASSWORD] = 1'($urandom_range(0, 1));
            end else begin
                fl = 8'($urandom_range(0, 255));
            end
            r = $urandom_range(0, 99);
            lvl = (r < 80) ? lvl_req : (r < 88) ? 8'd0 : (r < 94) ? 8'hFF :
                  8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            ka = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            id_len = (r < 15) ? 0 : (r < 75) ? $urandom_range(1, 6) :
                     (r < 88) ? $urandom_range(7, 24) : $urandom_range(200, 65535);
            // long strings are always cut short
            if (id_len > 24) cap = $urandom_range(8, 30);
            else if ($urandom_range(0, 99) < 18) cap = $urandom_range(0, 30);
            else cap = NO_CAP;
            build_connect(lvl, fl, ka, id_len, $urandom_range(0, 4), $urandom_range(0, 4),
                          $urandom_range(0, 4), $urandom_range(0, 4), cap,
                          ($urandom_range(0, 99) < 8) ? $urandom_range(1, 3) : 0,
                          $urandom_range(0, 99) < 5);
            send_body(hfl, $urandom_range(0, 99) < 93, $urandom_range(0, 99) < 96);
        end
    endtask

    // random messages up to the item mark, then a clean close
    task automatic random_phase(int upto);
        while (n_queued < upto) random_message();
        build_connect(lvl_req, 8'h02, 16'($urandom_range(0, 65535)), 3, 0, 0, 0, 0, NO_CAP, 0, 0);
        send_body(4'd0, 1'b1, 1'b1);
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || s_tvalid || verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_level(logic [7:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        lvl_req = v;
        n_levels++;
    endtask

    initial begin
        logic [7:0] lvl_plan[4];
        int n_causes;
        lvl_plan[0] = 8'hFF;
        lvl_plan[1] = 8'h00;
        lvl_plan[2] = 8'($urandom_range(1, 254));
        lvl_plan[3] = 8'd4;
        n_causes = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // bodyless message with nonzero fixed header flags
        body.delete();
        send_body(4'hF, 1'b1, 1'b1);
        // variable header cut after three bytes
        body.delete();
        body.push_back(8'h00);
        body.push_back(NAME_LEN_LO);
        body.push_back(PROTO_NAME[31:24]);
        send_body(4'd0, 1'b1, 1'b1);
        // shortest accepted connect: clean session, empty id, max keep alive
        build_connect(8'd4, 8'h02, 16'hFFFF, 0, 0, 0, 0, 0, NO_CAP, 0, 0);
        send_body(4'd0, 1'b1, 1'b1);
        // every flag bit but reserved: will QoS 3, stops inside the header
        build_connect(8'd4, 8'hFE, 16'h0000, 0, 0, 0, 0, 0, 8, 0, 0);
        send_body(4'd0, 1'b1, 1'b1);
        // one byte with no first marker: flags count as zero, short header
        body.delete();
        body.push_back(8'hFF);
        send_body(4'hA, 1'b0, 1'b1);

        random_phase(PHASE_ITEMS);
        for (int p = 0; p < 4; p++) begin
            drain();
            set_level(lvl_plan[p]);
            random_phase(PHASE_ITEMS * (p + 2));
        end
        drain();
        repeat (10) @(posedge aclk);

        foreach (cause_hit[c]) if (cause_hit[c]) n_causes++;
        $display("Checked %0d connect verdicts from %0d messages (%0d items) over %0d level settings",
                 n_results, n_msgs, n_queued, n_levels);
        $display("Error causes exercised: %0d of 16, mismatches: %0d", n_causes, mism);
        if (mism == 0 && verdict_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mqttcpc_pkg.sv
hw/rtl/mqtt_connect_packet_checker_core.sv
verif/tb_mqtt_connect_packet_checker_core.sv
